@@ hdl/cbp_pkg.sv @@
// shared types and constants for the chunky to byte-planar packer
`timescale 1ns / 1ps

package cbp_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_PLANE_LAYOUT = 2'd1;
  localparam logic [1:0] CFG_TOUCH_MASK = 2'd2;
  localparam logic [1:0] CFG_TRANSP_MASK = 2'd3;

  localparam int CFG_DATA_W = 24;
  localparam int SLOT_W = 3;
  localparam int LAYOUT_NIBBLES = 6;
  localparam int QUEUE_DEPTH = 2;

  // reset values of the registers
  localparam logic [12:0] RST_IMAGE_WIDTH = 13'd320;
  localparam logic [23:0] RST_PLANE_LAYOUT = 24'h008642;
  localparam logic [7:0] RST_TOUCH_MASK = 8'h02;
  localparam logic [7:0] RST_TRANSP_MASK = 8'h01;

  // plane slot codes
  localparam logic [3:0] CODE_UNUSED = 4'd0;
  localparam logic [3:0] CODE_BLUE_INV = 4'd1;
  localparam logic [3:0] CODE_BLUE = 4'd2;
  localparam logic [3:0] CODE_GREEN_INV = 4'd3;
  localparam logic [3:0] CODE_GREEN = 4'd4;
  localparam logic [3:0] CODE_RED_INV = 4'd5;
  localparam logic [3:0] CODE_RED = 4'd6;
  localparam logic [3:0] CODE_INTENS_INV = 4'd7;
  localparam logic [3:0] CODE_INTENS = 4'd8;
  localparam logic [3:0] CODE_HIT_INV = 4'd9;
  localparam logic [3:0] CODE_HIT = 4'd10;
  localparam logic [3:0] CODE_OPAQUE = 4'd11;
  localparam logic [3:0] CODE_OPAQUE_INV = 4'd12;

  // colour bits tested by the colour planes
  localparam logic [7:0] BIT_BLUE = 8'h01;
  localparam logic [7:0] BIT_GREEN = 8'h02;
  localparam logic [7:0] BIT_RED = 8'h04;
  localparam logic [7:0] BIT_INTENS = 8'h08;
  localparam logic [7:0] FIRST_PIXEL_BIT = 8'h80;

  typedef struct packed {
    logic [7:0] pixel_colour;
    logic [7:0] pixel_mask;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] plane_byte;
    logic [SLOT_W-1:0] slot_index;
    logic last_of_cell;
  } plane_out_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [23:0] plane_layout;
    logic [7:0] touch_mask_bit;
    logic [7:0] transparent_mask_bit;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ hdl/cbp_front.sv @@
// front end: pixel intake, per-slot bit accumulation and cell end detection
`timescale 1ns / 1ps

module cbp_front #(
  parameter int MAX_SLOTS = 6,
  parameter int MAX_WIDTH = 4096
) (
  input  logic clk,
  input  logic rst,
  input  cbp_pkg::cfg_t cfg,
  input  logic pix_valid,
  output logic pix_ready,
  input  cbp_pkg::pix_in_t pix,
  input  cbp_pkg::queue_status_t q_status,
  output logic push,
  output logic [MAX_SLOTS-1:0][7:0] push_bytes,
  output logic [MAX_SLOTS-1:0] push_used
);
  import cbp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam logic [CMPW-1:0] MAXW = CMPW'(MAX_WIDTH);

  logic [CW-1:0] column;
  logic [MAX_SLOTS-1:0][7:0] acc;
  logic [MAX_SLOTS-1:0][7:0] byte_now;
  logic [MAX_SLOTS-1:0] used;
  logic [2:0] pos;
  logic [CMPW-1:0] w_ext;
  logic [CMPW-1:0] w_eff;
  logic [CMPW-1:0] col_inc;
  logic row_end;
  logic cell_end;
  logic accept;

  // returns {selected, bit}
  function automatic logic [1:0] plane_bit(input logic [3:0] code, input logic [7:0] colour,
                                           input logic [7:0] mask, input logic [7:0] touch,
                                           input logic [7:0] transp);
    logic [1:0] r;
    r = 2'b00;
    unique case (code)
      CODE_BLUE_INV:   r = {1'b1, ~|(colour & BIT_BLUE)};
      CODE_BLUE:       r = {1'b1, |(colour & BIT_BLUE)};
      CODE_GREEN_INV:  r = {1'b1, ~|(colour & BIT_GREEN)};
      CODE_GREEN:      r = {1'b1, |(colour & BIT_GREEN)};
      CODE_RED_INV:    r = {1'b1, ~|(colour & BIT_RED)};
      CODE_RED:        r = {1'b1, |(colour & BIT_RED)};
      CODE_INTENS_INV: r = {1'b1, ~|(colour & BIT_INTENS)};
      CODE_INTENS:     r = {1'b1, |(colour & BIT_INTENS)};
      CODE_HIT_INV:    r = {1'b1, ~|(mask & touch)};
      CODE_HIT:        r = {1'b1, |(mask & touch)};
      CODE_OPAQUE:     r = {1'b1, |(mask & transp)};
      CODE_OPAQUE_INV: r = {1'b1, ~|(mask & transp)};
      default:         r = 2'b00;
    endcase
    return r;
  endfunction

  assign pos = column[2:0];
  assign accept = pix_valid && pix_ready;
  assign pix_ready = !q_status.full;

  always_comb begin
    logic [3:0] code;
    logic [1:0] pb;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      code = CODE_UNUSED;
      if (s < LAYOUT_NIBBLES) begin
        code = 4'(cfg.plane_layout >> (4 * s));
      end
      pb = plane_bit(code, pix.pixel_colour, pix.pixel_mask, cfg.touch_mask_bit,
                     cfg.transparent_mask_bit);
      used[s] = pb[1];
      byte_now[s] = acc[s] | ((pb[1] && pb[0]) ? (FIRST_PIXEL_BIT >> pos) : 8'h00);
    end
  end

  // width zero acts as one, anything above the maximum is clamped
  always_comb begin
    w_ext = CMPW'(cfg.image_width);
    if (w_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (w_ext > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = w_ext;
    end
  end

  assign col_inc = CMPW'(column) + CMPW'(1);
  assign row_end = (col_inc >= w_eff);
  assign cell_end = row_end || (pos == 3'd7);

  assign push = accept && cell_end && (|used);
  assign push_bytes = byte_now;
  assign push_used = used;

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      acc <= '0;
    end else if (accept) begin
      column <= row_end ? '0 : col_inc[CW-1:0];
      acc <= cell_end ? '0 : byte_now;
    end
  end

endmodule

@@ hdl/cbp_queue.sv @@
// small register queue carrying finished cells from front to back
`timescale 1ns / 1ps

module cbp_queue #(
  parameter int DW = 8,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [DW-1:0] push_data,
  input  logic pop,
  output logic [DW-1:0] pop_data,
  output cbp_pkg::queue_status_t status
);
  import cbp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CNTW-1:0] count;
  logic do_push;
  logic do_pop;

  assign status.full = (count == CNTW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

@@ hdl/cbp_back.sv @@
// back end: serializes each queued cell into one plane byte per used slot
`timescale 1ns / 1ps

module cbp_back #(
  parameter int MAX_SLOTS = 6
) (
  input  logic clk,
  input  logic rst,
  input  cbp_pkg::queue_status_t q_status,
  input  logic [MAX_SLOTS-1:0][7:0] q_bytes,
  input  logic [MAX_SLOTS-1:0] q_used,
  output logic pop,
  output logic plane_valid,
  input  logic plane_ready,
  output cbp_pkg::plane_out_t plane
);
  import cbp_pkg::*;

  logic work_valid;
  logic [MAX_SLOTS-1:0][7:0] work_bytes;
  logic [MAX_SLOTS-1:0] work_mask;
  logic [MAX_SLOTS-1:0] pick;
  logic [SLOT_W-1:0] pick_idx;
  logic last;
  logic advance;

  // lowest remaining slot goes first
  always_comb begin
    logic found;
    found = 1'b0;
    pick = '0;
    pick_idx = '0;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      if (work_mask[s] && !found) begin
        found = 1'b1;
        pick[s] = 1'b1;
        pick_idx = SLOT_W'(s);
      end
    end
  end

  assign last = ((work_mask & ~pick) == '0);
  assign advance = work_valid && (!plane_valid || plane_ready);
  assign pop = !q_status.empty && (!work_valid || (advance && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      work_mask <= '0;
    end else if (pop) begin
      work_valid <= 1'b1;
      work_mask <= q_used;
    end else if (advance) begin
      work_valid <= !last;
      work_mask <= work_mask & ~pick;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work_bytes <= q_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_valid <= 1'b0;
    end else if (advance) begin
      plane_valid <= 1'b1;
    end else if (plane_ready) begin
      plane_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      plane.plane_byte <= work_bytes[pick_idx];
      plane.slot_index <= pick_idx;
      plane.last_of_cell <= last;
    end
  end

  a_work_has_slots: assert property (@(posedge clk) disable iff (rst)
    work_valid |-> (work_mask != '0))
    else $error("working cell holds no slot");

  a_more_slots_stay: assert property (@(posedge clk) disable iff (rst)
    (advance && !last) |=> work_valid)
    else $error("cell dropped before its last slot");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> work_valid)
    else $error("popped cell not loaded");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> plane_valid)
    else $error("advanced byte not presented");

endmodule

@@ hdl/chunky_to_byteplanar_packer.sv @@
// top level of the chunky to byte-planar packer: config registers and block wiring
`timescale 1ns / 1ps

// channel   signals                               direction  item
// pixel     pix_valid / pix_ready / pix           in         colour and mask of one pixel
// plane     plane_valid / plane_ready / plane     out        one plane byte of a cell
// config    cfg_we / cfg_index / cfg_data         in         one register write
//
// one pixel is taken per cycle; the front needs space in the two-entry cell queue
// a finished cell yields one byte per used slot, one per cycle while plane_ready is high
// a cell's first byte passes the queue, the working cell register and the output register
// one pixel per cycle is sustained while plane_ready is high and bytes per cell <= pixels
// synchronous reset clears the column, the accumulators, the queue and the output stage
// a stall on the plane side fills the queue and then drops pix_ready

module chunky_to_byteplanar_packer #(
  parameter int MAX_SLOTS = 6,
  parameter int MAX_WIDTH = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  input  cbp_pkg::pix_in_t pix,
  output logic plane_valid,
  input  logic plane_ready,
  output cbp_pkg::plane_out_t plane,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbp_pkg::*;

  // queue entry: bytes of every slot plus the used-slot mask
  localparam int QW = MAX_SLOTS * 8 + MAX_SLOTS;

  cfg_t cfg;
  queue_status_t q_status;
  logic push;
  logic pop;
  logic [MAX_SLOTS-1:0][7:0] push_bytes;
  logic [MAX_SLOTS-1:0] push_used;
  logic [MAX_SLOTS-1:0][7:0] q_bytes;
  logic [MAX_SLOTS-1:0] q_used;
  logic [QW-1:0] q_out;

  // configuration registers: user writes only while the block is idle, not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= RST_IMAGE_WIDTH;
      cfg.plane_layout <= RST_PLANE_LAYOUT;
      cfg.touch_mask_bit <= RST_TOUCH_MASK;
      cfg.transparent_mask_bit <= RST_TRANSP_MASK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg.image_width <= cfg_data[12:0];
        CFG_PLANE_LAYOUT: cfg.plane_layout <= cfg_data[23:0];
        CFG_TOUCH_MASK:   cfg.touch_mask_bit <= cfg_data[7:0];
        CFG_TRANSP_MASK:  cfg.transparent_mask_bit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // front: accumulates pixels into slot bytes, pushes a cell at its end
  cbp_front #(
    .MAX_SLOTS(MAX_SLOTS),
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix(pix),
    .q_status(q_status),
    .push(push),
    .push_bytes(push_bytes),
    .push_used(push_used)
  );

  // decoupling queue between front and back
  cbp_queue #(
    .DW(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data({push_bytes, push_used}),
    .pop(pop),
    .pop_data(q_out),
    .status(q_status)
  );

  assign q_bytes = q_out[QW-1:MAX_SLOTS];
  assign q_used = q_out[MAX_SLOTS-1:0];

  // back: emits one byte per used slot, in slot order, last one flagged
  cbp_back #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_status(q_status),
    .q_bytes(q_bytes),
    .q_used(q_used),
    .pop(pop),
    .plane_valid(plane_valid),
    .plane_ready(plane_ready),
    .plane(plane)
  );

endmodule
